FILE: src/pcrg_pkg.sv
// ----------------------------------------------------------------------------
// Pinhole camera ray generator package
// Field widths, fixed-point formats, register indexes and channel payloads.
// ----------------------------------------------------------------------------
`default_nettype none

package pcrg_pkg;

  // Port field widths
  localparam int PIX_W      = 16;
  localparam int SCALE_W    = 16;
  localparam int COMP_W     = 16;
  localparam int NCOMP      = 3;
  localparam int VEC_W      = NCOMP * COMP_W;
  localparam int ORIGIN_W   = 32;
  localparam int DIR_W      = 16;
  localparam int CFG_DATA_W = 48;
  localparam int CFG_IDX_W  = 3;

  // Default fraction width of the output direction
  localparam int DIR_FRAC_BITS_DEF = 14;

  // Screen offsets carry 16 + 10 fraction bits
  localparam int OFFS_FRAC = 26;
  // Largest magnitude is normalized into [2^29, 2^30)
  localparam int NORM_TOP  = 29;

  // Datapath widths
  localparam int T_W     = PIX_W + 2;              // 2u-1 and 1-2v, Q1.16 signed
  localparam int NXF_W   = T_W + SCALE_W + 1;      // full offset product
  localparam int NX_W    = 33;                     // |offset| < 2^32
  localparam int PROD_W  = COMP_W + NX_W;          // basis times offset
  localparam int SUM_W   = PROD_W + 1;             // unnormalized direction
  localparam int MAG_W   = SUM_W - 1;              // its magnitude
  localparam int GRP_W   = 8;
  localparam int GRP_N   = (MAG_W + GRP_W - 1) / GRP_W;
  localparam int PAD_W   = GRP_N * GRP_W;
  localparam int POS_W   = $clog2(GRP_W);
  localparam int TOP_W   = $clog2(PAD_W);
  localparam int SHW_W   = MAG_W + NORM_TOP;
  localparam int A_W     = NORM_TOP + 1;           // normalized magnitude
  localparam int SQ_W    = 2 * A_W;
  localparam int SSQ_W   = SQ_W + 2;               // sum of three squares
  localparam int LEN_W   = SSQ_W / 2;              // floor square root
  localparam int SQRT_STAGES = LEN_W;              // one root bit per stage
  localparam int REM_W   = LEN_W + 1;              // root remainder

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(1024);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FORWARD  = 3'd0,
    CFG_RIGHT    = 3'd1,
    CFG_UP       = 3'd2,
    CFG_SCALE_X  = 3'd3,
    CFG_SCALE_Y  = 3'd4,
    CFG_ORIGIN_X = 3'd5,
    CFG_ORIGIN_Y = 3'd6,
    CFG_ORIGIN_Z = 3'd7
  } cfg_reg_t;

  // Pixel request
  typedef struct packed {
    logic [PIX_W-1:0] pixel_u;
    logic [PIX_W-1:0] pixel_v;
  } pix_t;

  // Ray result
  typedef struct packed {
    logic signed [ORIGIN_W-1:0] ray_origin_x;
    logic signed [ORIGIN_W-1:0] ray_origin_y;
    logic signed [ORIGIN_W-1:0] ray_origin_z;
    logic signed [DIR_W-1:0]    dir_x;
    logic signed [DIR_W-1:0]    dir_y;
    logic signed [DIR_W-1:0]    dir_z;
    logic                       degenerate;
  } ray_t;

endpackage

`default_nettype wire

FILE: src/pinhole_camera_ray_generator.sv
// ----------------------------------------------------------------------------
// Pinhole camera ray generator
// Throughput: one pixel request per cycle while pix_stall is low.
// Depth: the 31-stage square-root chain and the DIR_FRAC_BITS + 1 stage
// divider lie between an accepted request and its ray_valid.
// Reset: clears the pipeline valids and the output skid, and loads the
// register defaults (zero basis and origin, unit scales).
// ----------------------------------------------------------------------------
`default_nettype none

module pinhole_camera_ray_generator #(
  parameter int DIR_FRAC_BITS = pcrg_pkg::DIR_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration writes
  input  logic                             cfg_we,
  input  logic [pcrg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pcrg_pkg::CFG_DATA_W-1:0]  cfg_data,
  // pixel requests
  input  logic                             pix_valid,
  output logic                             pix_stall,
  input  pcrg_pkg::pix_t                   pix,
  // ray results
  output logic                             ray_valid,
  input  logic                             ray_stall,
  output pcrg_pkg::ray_t                   ray
);

  import pcrg_pkg::*;

  localparam int Q_W    = DIR_FRAC_BITS + 1;           // quotient bits
  localparam int NUM_W  = A_W + DIR_FRAC_BITS + 1;     // dividend bits
  localparam int EXT_W  = (Q_W > DIR_W) ? Q_W : DIR_W;
  localparam int CAND_W = REM_W + 2;

  // Square-root stage payload
  typedef struct packed {
    logic [REM_W-1:0]            rem;
    logic [LEN_W-1:0]            root;
    logic [SSQ_W-1:0]            ssq;
    logic [NCOMP-1:0][A_W-1:0]   a;
    logic [NCOMP-1:0]            neg;
  } sqrt_stage_t;

  // Divider stage payload
  typedef struct packed {
    logic [NCOMP-1:0][NUM_W-1:0] rem;
    logic [NCOMP-1:0][Q_W-1:0]   q;
    logic [LEN_W-1:0]            len;
    logic [NCOMP-1:0]            neg;
  } div_stage_t;

  // Finished direction
  typedef struct packed {
    logic [NCOMP-1:0][DIR_W-1:0] dir;
    logic                        degen;
  } dir_res_t;

  // One signed basis component
  function automatic logic signed [COMP_W-1:0] comp_of(input logic [VEC_W-1:0] v,
                                                       input logic [1:0] i);
    return $signed(v[COMP_W*i +: COMP_W]);
  endfunction

  // One digit of the floor square root
  function automatic sqrt_stage_t sqrt_step(input sqrt_stage_t cur);
    sqrt_stage_t      nxt;
    logic [CAND_W-1:0] cand;
    logic [CAND_W-1:0] trial;
    logic [CAND_W-1:0] diff;
    logic              ge;
    nxt   = cur;
    cand  = {cur.rem, cur.ssq[SSQ_W-1 -: 2]};
    trial = CAND_W'({cur.root, 2'b01});
    diff  = cand - trial;
    ge    = (cand >= trial);
    nxt.rem  = ge ? diff[REM_W-1:0] : cand[REM_W-1:0];
    nxt.root = {cur.root[LEN_W-2:0], ge};
    nxt.ssq  = cur.ssq << 2;
    return nxt;
  endfunction

  // One quotient bit per lane, divisor aligned to bit b
  function automatic div_stage_t div_step(input div_stage_t cur, input int b);
    div_stage_t       nxt;
    logic [NUM_W-1:0] sh;
    logic             ge;
    nxt = cur;
    sh  = NUM_W'(cur.len) << b;
    for (int i = 0; i < NCOMP; i++) begin
      ge = (cur.rem[i] >= sh);
      nxt.rem[i] = ge ? (cur.rem[i] - sh) : cur.rem[i];
      nxt.q[i]   = {cur.q[i][Q_W-2:0], ge};
    end
    return nxt;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [VEC_W-1:0]           forward_vec, right_vec, up_vec;
  logic [SCALE_W-1:0]         scale_x, scale_y;
  logic signed [ORIGIN_W-1:0] origin_x, origin_y, origin_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      forward_vec <= '0;
      right_vec   <= '0;
      up_vec      <= '0;
      scale_x     <= SCALE_RESET;
      scale_y     <= SCALE_RESET;
      origin_x    <= '0;
      origin_y    <= '0;
      origin_z    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_FORWARD:  forward_vec <= cfg_data[VEC_W-1:0];
        CFG_RIGHT:    right_vec   <= cfg_data[VEC_W-1:0];
        CFG_UP:       up_vec      <= cfg_data[VEC_W-1:0];
        CFG_SCALE_X:  scale_x     <= cfg_data[SCALE_W-1:0];
        CFG_SCALE_Y:  scale_y     <= cfg_data[SCALE_W-1:0];
        CFG_ORIGIN_X: origin_x    <= $signed(cfg_data[ORIGIN_W-1:0]);
        CFG_ORIGIN_Y: origin_y    <= $signed(cfg_data[ORIGIN_W-1:0]);
        CFG_ORIGIN_Z: origin_z    <= $signed(cfg_data[ORIGIN_W-1:0]);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Flow control: whole pipe moves unless the output skid is occupied
  // --------------------------------------------------------------------------
  logic en;
  logic skid_full;

  assign en        = ~skid_full;
  assign pix_stall = skid_full;

  // --------------------------------------------------------------------------
  // Pipeline registers
  // --------------------------------------------------------------------------
  logic v1, v2, v3, v4, v5, v6, v7, v8, v9, di_vld, o_vld;
  logic [SQRT_STAGES-1:0] sq_vld;
  logic [Q_W-1:0]         dv_vld;

  logic signed [NX_W-1:0]   s1_nx, s1_ny;
  logic signed [PROD_W-1:0] s2_pr [NCOMP];
  logic signed [PROD_W-1:0] s2_pu [NCOMP];
  logic signed [SUM_W-1:0]  s3_sum [NCOMP];
  logic [MAG_W-1:0]         s4_mag [NCOMP];
  logic [NCOMP-1:0]         s4_neg;
  logic [MAG_W-1:0]         s5_mag [NCOMP];
  logic [NCOMP-1:0]         s5_neg;
  logic [GRP_N-1:0]         s5_nz;
  logic [POS_W-1:0]         s5_pos [GRP_N];
  logic [MAG_W-1:0]         s6_mag [NCOMP];
  logic [NCOMP-1:0]         s6_neg;
  logic [TOP_W-1:0]         s6_top;
  logic [NCOMP-1:0][A_W-1:0] s7_a;
  logic [NCOMP-1:0]         s7_neg;
  logic [SQ_W-1:0]          s8_sq [NCOMP];
  logic [NCOMP-1:0][A_W-1:0] s8_a;
  logic [NCOMP-1:0]         s8_neg;
  logic [SSQ_W-1:0]         s9_ssq;
  logic [NCOMP-1:0][A_W-1:0] s9_a;
  logic [NCOMP-1:0]         s9_neg;
  sqrt_stage_t              sq_q [SQRT_STAGES];
  div_stage_t               di_q;
  div_stage_t               dv_q [Q_W];
  dir_res_t                 o_q;
  dir_res_t                 sk_q;

  // --------------------------------------------------------------------------
  // Combinational pieces of each stage
  // --------------------------------------------------------------------------
  logic signed [T_W-1:0]      tu, tv;
  logic signed [NXF_W-1:0]    nx_full, ny_full;
  logic signed [PROD_W-1:0]   pr_w [NCOMP];
  logic signed [PROD_W-1:0]   pu_w [NCOMP];
  logic signed [SUM_W-1:0]    sum_w [NCOMP];
  logic [SUM_W-1:0]           abs_w [NCOMP];
  logic [PAD_W-1:0]           mpad;
  logic [GRP_N-1:0]           nz_w;
  logic [POS_W-1:0]           pos_w [GRP_N];
  logic [TOP_W-1:0]           top_w;
  logic [SHW_W-1:0]           shw_w [NCOMP];
  logic [SQ_W-1:0]            sq_w [NCOMP];
  sqrt_stage_t                sq_init;
  div_stage_t                 di_w;
  dir_res_t                   o_w;
  logic [EXT_W-1:0]           qe;
  logic [EXT_W-1:0]           qn;

  // Stage 1: screen offsets
  always_comb begin
    tu      = $signed({1'b0, pix.pixel_u, 1'b0}) - T_W'(65536);
    tv      = T_W'(65536) - $signed({1'b0, pix.pixel_v, 1'b0});
    nx_full = NXF_W'(tu) * NXF_W'($signed({1'b0, scale_x}));
    ny_full = NXF_W'(tv) * NXF_W'($signed({1'b0, scale_y}));
  end

  // Stage 2: basis times offsets
  always_comb begin
    for (int i = 0; i < NCOMP; i++) begin
      pr_w[i] = PROD_W'(comp_of(right_vec, 2'(i))) * PROD_W'(s1_nx);
      pu_w[i] = PROD_W'(comp_of(up_vec, 2'(i))) * PROD_W'(s1_ny);
    end
  end

  // Stage 3: exact direction sum
  always_comb begin
    for (int i = 0; i < NCOMP; i++) begin
      sum_w[i] = (SUM_W'(comp_of(forward_vec, 2'(i))) <<< OFFS_FRAC)
               + SUM_W'(s2_pr[i]) + SUM_W'(s2_pu[i]);
    end
  end

  // Stage 4: sign and magnitude
  always_comb begin
    for (int i = 0; i < NCOMP; i++) begin
      abs_w[i] = s3_sum[i][SUM_W-1] ? ((~s3_sum[i]) + SUM_W'(1)) : s3_sum[i];
    end
  end

  // Stage 5: leading-one per byte group of the OR of magnitudes
  always_comb begin
    mpad = PAD_W'(s4_mag[0] | s4_mag[1] | s4_mag[2]);
    for (int g = 0; g < GRP_N; g++) begin
      nz_w[g]  = |mpad[g*GRP_W +: GRP_W];
      pos_w[g] = '0;
      for (int b = 0; b < GRP_W; b++) begin
        if (mpad[g*GRP_W + b]) pos_w[g] = POS_W'(b);
      end
    end
  end

  // Stage 6: highest nonzero group gives the top bit index
  always_comb begin
    top_w = '0;
    for (int g = 0; g < GRP_N; g++) begin
      if (s5_nz[g]) top_w = TOP_W'(g * GRP_W) + TOP_W'(s5_pos[g]);
    end
  end

  // Stage 7: common normalizing shift, truncating
  always_comb begin
    for (int i = 0; i < NCOMP; i++) begin
      shw_w[i] = {s6_mag[i], {NORM_TOP{1'b0}}} >> s6_top;
    end
  end

  // Stage 8: squares
  always_comb begin
    for (int i = 0; i < NCOMP; i++) begin
      sq_w[i] = SQ_W'(s7_a[i]) * SQ_W'(s7_a[i]);
    end
  end

  // Square-root chain entry
  always_comb begin
    sq_init.rem  = '0;
    sq_init.root = '0;
    sq_init.ssq  = s9_ssq;
    sq_init.a    = s9_a;
    sq_init.neg  = s9_neg;
  end

  // Divider entry: dividend a*2^F + len/2
  always_comb begin
    di_w.len = sq_q[SQRT_STAGES-1].root;
    di_w.neg = sq_q[SQRT_STAGES-1].neg;
    for (int i = 0; i < NCOMP; i++) begin
      di_w.rem[i] = NUM_W'({sq_q[SQRT_STAGES-1].a[i], {DIR_FRAC_BITS{1'b0}}})
                  + NUM_W'(sq_q[SQRT_STAGES-1].root >> 1);
      di_w.q[i]   = '0;
    end
  end

  // Final: apply signs, zero length forces a zero direction
  always_comb begin
    o_w.degen = (dv_q[Q_W-1].len == '0);
    qe = '0;
    qn = '0;
    for (int i = 0; i < NCOMP; i++) begin
      qe = EXT_W'(dv_q[Q_W-1].q[i]);
      qn = (~qe) + EXT_W'(1);
      if (o_w.degen) begin
        o_w.dir[i] = '0;
      end else if (dv_q[Q_W-1].neg[i]) begin
        o_w.dir[i] = qn[DIR_W-1:0];
      end else begin
        o_w.dir[i] = qe[DIR_W-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Valid bits travel with the data
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
      v6 <= 1'b0; v7 <= 1'b0; v8 <= 1'b0; v9 <= 1'b0;
      sq_vld <= '0;
      di_vld <= 1'b0;
      dv_vld <= '0;
      o_vld  <= 1'b0;
    end else if (en) begin
      v1 <= pix_valid;
      v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4;
      v6 <= v5; v7 <= v6; v8 <= v7; v9 <= v8;
      sq_vld <= {sq_vld[SQRT_STAGES-2:0], v9};
      di_vld <= sq_vld[SQRT_STAGES-1];
      dv_vld <= {dv_vld[Q_W-2:0], di_vld};
      o_vld  <= dv_vld[Q_W-1];
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (en) begin
      s1_nx <= nx_full[NX_W-1:0];
      s1_ny <= ny_full[NX_W-1:0];
      for (int i = 0; i < NCOMP; i++) begin
        s2_pr[i]  <= pr_w[i];
        s2_pu[i]  <= pu_w[i];
        s3_sum[i] <= sum_w[i];
        s4_mag[i] <= abs_w[i][MAG_W-1:0];
        s4_neg[i] <= s3_sum[i][SUM_W-1];
        s5_mag[i] <= s4_mag[i];
        s6_mag[i] <= s5_mag[i];
        s7_a[i]   <= shw_w[i][A_W-1:0];
        s8_sq[i]  <= sq_w[i];
      end
      s5_neg <= s4_neg;
      s5_nz  <= nz_w;
      for (int g = 0; g < GRP_N; g++) begin
        s5_pos[g] <= pos_w[g];
      end
      s6_neg <= s5_neg;
      s6_top <= top_w;
      s7_neg <= s6_neg;
      s8_a   <= s7_a;
      s8_neg <= s7_neg;
      s9_ssq <= SSQ_W'(s8_sq[0]) + SSQ_W'(s8_sq[1]) + SSQ_W'(s8_sq[2]);
      s9_a   <= s8_a;
      s9_neg <= s8_neg;

      // square root, one result bit per stage
      sq_q[0] <= sqrt_step(sq_init);
      for (int j = 1; j < SQRT_STAGES; j++) begin
        sq_q[j] <= sqrt_step(sq_q[j-1]);
      end

      // restoring divider, one quotient bit per stage, MSB first
      di_q     <= di_w;
      dv_q[0]  <= div_step(di_q, Q_W - 1);
      for (int k = 1; k < Q_W; k++) begin
        dv_q[k] <= div_step(dv_q[k-1], Q_W - 1 - k);
      end

      o_q <= o_w;
    end
  end

  // --------------------------------------------------------------------------
  // Output skid: catches the last stage when the consumer stalls
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (!ray_stall) skid_full <= 1'b0;
    end else if (o_vld && ray_stall) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full) sk_q <= o_q;
  end

  // Result assembly
  dir_res_t res_sel;

  always_comb begin
    res_sel          = skid_full ? sk_q : o_q;
    ray.ray_origin_x = origin_x;
    ray.ray_origin_y = origin_y;
    ray.ray_origin_z = origin_z;
    ray.dir_x        = $signed(res_sel.dir[0]);
    ray.dir_y        = $signed(res_sel.dir[1]);
    ray.dir_z        = $signed(res_sel.dir[2]);
    ray.degenerate   = res_sel.degen;
  end

  assign ray_valid = skid_full | o_vld;

endmodule

`default_nettype wire
